// File: hw/rtl/npf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next prime finder package
// Transfer types, sequencer states and fixed constants shared by the
// next prime finder and its remainder unit.
// ----------------------------------------------------------------------------
package npf_pkg;

    // Width of the value fields on both channels.
    localparam int VALUE_BITS = 32;

    // Item modes.
    localparam logic FUNC_TEST = 1'b0;
    localparam logic FUNC_NEXT = 1'b1;

    // 6k+-1 trial division constants.
    localparam int DIV_SMALL = 3;   // divisor used for the multiple-of-three check
    localparam int DIV_FIRST = 5;   // first trial divisor
    localparam int DIV_PAIR  = 2;   // offset of the second divisor of a pair
    localparam int DIV_STEP  = 6;   // spacing of the divisor pairs
    localparam int SQ_FIRST  = 25;  // square of the first trial divisor
    localparam int SQ_BIAS   = 36;  // (d+6)^2 - d^2 = 12*d + 36

    // One input item.
    typedef struct packed {
        logic                  func;
        logic [VALUE_BITS-1:0] value;
    } t_in;

    // One result item.
    typedef struct packed {
        logic                  prime_flag;
        logic [VALUE_BITS-1:0] prime_value;
        logic                  overflow;
    } t_out;

    // Status returned by the remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_TEST = 8'b0000_0010,
        ST_MOD3 = 8'b0000_0100,
        ST_SQ   = 8'b0000_1000,
        ST_DIVA = 8'b0001_0000,
        ST_DIVB = 8'b0010_0000,
        ST_NEXT = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/npf_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next prime finder remainder unit
// Restoring remainder, one dividend bit per cycle. A start pulse loads the
// operands; after the last step a done pulse comes with the zero-remainder flag.
// ----------------------------------------------------------------------------
module npf_rem #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_dividend,
    input  logic [W-1:0]         i_divisor,
    output npf_pkg::t_rem_status o_status
);
    import npf_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvd;
    logic [W-1:0]  r_dvs;

    logic [W:0]    trial;
    logic [W-1:0]  n_rem;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        trial = {r_rem, r_dvd[W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[W-1:0];
        end
    end

    // Step counter and handshake flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

`ifndef ASSERT_OFF
    // A new operation is never started over one in progress.
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    // The done pulse comes only after the last step.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("remainder done while still busy");

    // A busy unit always has steps left to count.
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("remainder unit busy with no steps left");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/next_prime_finder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Run time is data dependent. Each remainder runs in the shared
// bit-serial remainder unit (W = min(WORD_BITS, 32)); a test of n runs about
// one remainder for the factor 3 plus two per divisor pair up to sqrt(n),
// and mode 1 repeats that per candidate.
// Throughput: one item at a time; the input stalls until the result is in
// the output register. Reset returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
// Next prime finder
// Tests a value for primality by 6k+-1 trial division, or searches upward
// from 2*value+1 for the smallest prime, flagging overflow past the word.
// ----------------------------------------------------------------------------
module next_prime_finder_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  npf_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output npf_pkg::t_out  o_out_data
);
    import npf_pkg::*;

    // Working width: the word, limited by the 32-bit value field.
    localparam int W = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;

    t_state       r_state, n_state;
    logic         r_func, n_func;
    logic [W-1:0] r_n, n_n;
    logic [W-1:0] r_d, n_d;
    logic [W:0]   r_sq, n_sq;
    logic         r_prime, n_prime;
    logic         r_ovf, n_ovf;
    logic         r_out_valid;
    t_out         r_out;

    logic         out_load;
    logic         div_start;
    logic [W-1:0] div_divisor;
    logic [W-1:0] in_v;
    logic [W+1:0] sq_inc;
    t_rem_status  s_div;

    assign in_v = i_in_data.value[W-1:0];

    // Growth of the divisor square when d steps by six: 12*d + 36.
    assign sq_inc = ((W+2)'(r_d) << 3) + ((W+2)'(r_d) << 2) + (W+2)'(SQ_BIAS);

    // Shared remainder unit.
    npf_rem #(
        .W (W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_n),
        .i_divisor  (div_divisor),
        .o_status   (s_div)
    );

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_n         = r_n;
        n_d         = r_d;
        n_sq        = r_sq;
        n_prime     = r_prime;
        n_ovf       = r_ovf;
        out_load    = 1'b0;
        div_start   = 1'b0;
        div_divisor = r_d;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_in_data.func;
                    n_ovf  = 1'b0;
                    if (i_in_data.func == FUNC_NEXT) begin
                        if (in_v[W-1]) begin
                            // 2*value+1 is already past the word.
                            n_ovf   = 1'b1;
                            n_prime = 1'b0;
                            n_state = ST_DONE;
                        end else begin
                            n_n     = {in_v[W-2:0], 1'b1};
                            n_state = ST_TEST;
                        end
                    end else begin
                        n_n     = in_v;
                        n_state = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                // Small values and even numbers are settled at once.
                if (r_n <= W'(1)) begin
                    n_prime = 1'b0;
                    n_state = ST_NEXT;
                end else if (r_n <= W'(DIV_SMALL)) begin
                    n_prime = 1'b1;
                    n_state = ST_NEXT;
                end else if (!r_n[0]) begin
                    n_prime = 1'b0;
                    n_state = ST_NEXT;
                end else begin
                    div_start   = 1'b1;
                    div_divisor = W'(DIV_SMALL);
                    n_d         = W'(DIV_FIRST);
                    n_sq        = (W+1)'(SQ_FIRST);
                    n_state     = ST_MOD3;
                end
            end
            ST_MOD3: begin
                if (s_div.done) begin
                    if (s_div.zero) begin
                        n_prime = 1'b0;
                        n_state = ST_NEXT;
                    end else begin
                        n_state = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                // Stop once d*d passes n; otherwise try d.
                if (r_sq > {1'b0, r_n}) begin
                    n_prime = 1'b1;
                    n_state = ST_NEXT;
                end else begin
                    div_start   = 1'b1;
                    div_divisor = r_d;
                    n_state     = ST_DIVA;
                end
            end
            ST_DIVA: begin
                if (s_div.done) begin
                    if (s_div.zero) begin
                        n_prime = 1'b0;
                        n_state = ST_NEXT;
                    end else begin
                        div_start   = 1'b1;
                        div_divisor = r_d + W'(DIV_PAIR);
                        n_state     = ST_DIVB;
                    end
                end
            end
            ST_DIVB: begin
                if (s_div.done) begin
                    if (s_div.zero) begin
                        n_prime = 1'b0;
                        n_state = ST_NEXT;
                    end else begin
                        n_d     = r_d + W'(DIV_STEP);
                        n_sq    = r_sq + sq_inc[W:0];
                        n_state = ST_SQ;
                    end
                end
            end
            ST_NEXT: begin
                // A verdict ends a test; a search moves to the next candidate.
                if (r_func == FUNC_TEST || r_prime) begin
                    n_state = ST_DONE;
                end else if (r_n == '1) begin
                    n_ovf   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_n     = r_n + W'(1);
                    n_state = ST_TEST;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_n     <= n_n;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_prime <= n_prime;
        r_ovf   <= n_ovf;
        if (out_load) begin
            r_out.prime_flag  <= r_prime;
            r_out.prime_value <= r_ovf ? '0 : VALUE_BITS'(r_n);
            r_out.overflow    <= r_ovf;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // An accepted item always moves the sequencer out of idle.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state != ST_IDLE))
        else $error("accepted transfer left the sequencer idle");

    // The remainder unit only finishes while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div.done |-> (r_state == ST_MOD3 || r_state == ST_DIVA || r_state == ST_DIVB))
        else $error("remainder finished outside a wait state");

    // An overflow result never reports a prime.
    a_ovf_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
            (!o_out_data.prime_flag && o_out_data.prime_value == '0))
        else $error("overflow result carries a prime");
`endif

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next prime finder testbench
// Drives test and next-prime items through the valid/stall input channel,
// predicts every answer with an independent trial-division model, and
// checks each result transfer in order. Both channels idle at random, and
// the result side holds off for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import npf_pkg::*;

    // Block configuration and derived arithmetic limits.
    localparam int WORD_BITS = 32;
    localparam longint unsigned WORD_MASK =
        ((64'd1 << (WORD_BITS - 1)) << 1) - 64'd1;
    localparam longint unsigned SEARCH_LIMIT = WORD_MASK & 64'hFFFF_FFFF;

    // Run shape.
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 76;
    localparam int IDLE_PCT      = 16;
    localparam int SEND_QUIET_LO = 40;
    localparam int SEND_QUIET_HI = 70;
    localparam int RECV_QUIET_LO = 60;
    localparam int RECV_QUIET_HI = 85;
    localparam int PRESSURE_AT   = 30;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 200;
    localparam int MAX_REPORTS   = 10;

    // The costliest item is a full divisor sweep of a value near 2^24
    // (about 1400 remainders); the limit leaves a wide margin even over a
    // run made only of the worst random items.
    localparam int unsigned CYCLE_LIMIT = 6_000_000;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    logic  o_in_stall;
    t_in   i_in_data   = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_data;

    int unsigned cycle_count = 0;

    // Expected answers and the trial-division predictor that produces them.
    class prime_scoreboard;
        t_out        pending_answers[$];
        int unsigned mismatch_count = 0;

        function bit trial_prime(longint unsigned n);
            longint unsigned d;
            if (n <= 1) return 1'b0;
            if (n <= 3) return 1'b1;
            if (n % 2 == 0 || n % DIV_SMALL == 0) return 1'b0;
            for (d = DIV_FIRST; d * d <= n; d += DIV_STEP) begin
                if (n % d == 0 || n % (d + DIV_PAIR) == 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function t_out predict_answer(t_in item);
            t_out            ans;
            longint unsigned v;
            longint unsigned cand;
            bit              found;
            ans = '0;
            v   = {32'd0, item.value} & WORD_MASK;
            if (item.func == FUNC_TEST) begin
                ans.prime_flag  = trial_prime(v);
                ans.prime_value = v[31:0];
            end else begin
                // Search upward from twice the capacity plus one.
                cand  = 2 * v + 1;
                found = 1'b0;
                while (!found && cand <= SEARCH_LIMIT) begin
                    if (trial_prime(cand)) found = 1'b1;
                    else cand++;
                end
                if (found) begin
                    ans.prime_flag  = 1'b1;
                    ans.prime_value = cand[31:0];
                end else begin
                    ans.overflow = 1'b1;
                end
            end
            return ans;
        endfunction

        function void record_request(t_in item);
            pending_answers.push_back(predict_answer(item));
        endfunction

        function void check_answer(t_out got);
            t_out want;
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR: unexpected result prime_flag=%0d prime_value=%h overflow=%0d",
                             got.prime_flag, got.prime_value, got.overflow);
                return;
            end
            want = pending_answers.pop_front();
            if (got.prime_flag !== want.prime_flag || got.prime_value !== want.prime_value ||
                got.overflow !== want.overflow) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"ERROR: expected prime_flag=%0d prime_value=%h overflow=%0d,",
                              " got prime_flag=%0d prime_value=%h overflow=%0d"},
                             want.prime_flag, want.prime_value, want.overflow,
                             got.prime_flag, got.prime_value, got.overflow);
            end
        endfunction

        function int unsigned outstanding();
            return pending_answers.size();
        endfunction
    endclass

    prime_scoreboard sb = new();

    next_prime_finder_unit #(
        .WORD_BITS (WORD_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Clock, 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Cycle counter for the watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Offer one item and hold it until the transfer happens.
    task automatic offer(input logic func, input logic [31:0] value, input bit may_idle);
        t_in item;
        item.func  = func;
        item.value = value;
        if (may_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        sb.record_request(item);
    endtask

    // Random item mix: sizes are kept small where a prime would cost a long
    // divisor sweep, while large values are shaped to have small factors.
    function automatic t_in make_random_item();
        t_in         item;
        int unsigned pick;
        pick       = $urandom_range(0, 99);
        item.func  = FUNC_TEST;
        item.value = '0;
        if (pick < 35) begin
            item.value = $urandom_range(0, 16'hFFFF);
        end else if (pick < 45) begin
            item.value = $urandom_range(0, 20'hF_FFFF);
        end else if (pick < 60) begin
            item.value = $urandom & 32'hFFFF_FFFE;
        end else if (pick < 65) begin
            item.value = 3 * $urandom_range(0, 32'h5555_5555);
        end else if (pick < 70) begin
            item.value = 5 * $urandom_range(0, 32'h3333_3333);
        end else if (pick < 95) begin
            item.func  = FUNC_NEXT;
            item.value = $urandom_range(0, 4095);
        end else begin
            item.func  = FUNC_NEXT;
            item.value = 32'h8000_0000 | $urandom;
        end
        return item;
    endfunction

    // Result side: check every transfer and decide the next stall.
    initial begin
        int unsigned results_seen;
        int unsigned hold_left;
        bit          hold_done;
        results_seen = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                sb.check_answer(o_out_data);
                results_seen++;
            end
            // One long hold-off lets the input side back up behind a result.
            if (results_seen == PRESSURE_AT && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (results_seen >= RECV_QUIET_LO && results_seen < RECV_QUIET_HI) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        t_in item;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Primality tests: below two, two and three, multiples of two and
        // three, squares caught only by the inclusive divisor bound, a hit on
        // the second divisor of a pair, primes, and the all-ones word.
        offer(FUNC_TEST, 32'd0, 1'b1);
        offer(FUNC_TEST, 32'd1, 1'b1);
        offer(FUNC_TEST, 32'd2, 1'b1);
        offer(FUNC_TEST, 32'd3, 1'b1);
        offer(FUNC_TEST, 32'd4, 1'b1);
        offer(FUNC_TEST, 32'd5, 1'b1);
        offer(FUNC_TEST, 32'd9, 1'b1);
        offer(FUNC_TEST, 32'd25, 1'b1);
        offer(FUNC_TEST, 32'd35, 1'b1);
        offer(FUNC_TEST, 32'd49, 1'b1);
        offer(FUNC_TEST, 32'd97, 1'b1);
        offer(FUNC_TEST, 32'd121, 1'b1);
        offer(FUNC_TEST, 32'd65537, 1'b1);
        offer(FUNC_TEST, 32'd1042441, 1'b1);
        offer(FUNC_TEST, 32'd16777213, 1'b1);
        offer(FUNC_TEST, 32'hFFFF_FFFE, 1'b1);
        offer(FUNC_TEST, 32'hFFFF_FFFF, 1'b1);

        // Next-prime searches: tiny capacities, a composite start, a search
        // that runs off the end of the word, and starts already too large.
        offer(FUNC_NEXT, 32'd0, 1'b1);
        offer(FUNC_NEXT, 32'd1, 1'b1);
        offer(FUNC_NEXT, 32'd2, 1'b1);
        offer(FUNC_NEXT, 32'd12, 1'b1);
        offer(FUNC_NEXT, 32'h7FFF_FFFF, 1'b1);
        offer(FUNC_NEXT, 32'h8000_0000, 1'b1);
        offer(FUNC_NEXT, 32'hFFFF_FFFF, 1'b1);

        for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
            item = make_random_item();
            offer(item.func, item.value, !(idx >= SEND_QUIET_LO && idx < SEND_QUIET_HI));
        end
        i_in_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/npf_pkg.sv
hw/rtl/npf_rem.sv
hw/rtl/next_prime_finder_unit.sv
verif/tb_top.sv
